// File: rtl/four_step_pitch_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// Four-step pitch sequencer assertion macros
// Concurrent assertion helpers shared by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef FOUR_STEP_PITCH_SEQUENCER_UNIT_DEFINES_SVH
`define FOUR_STEP_PITCH_SEQUENCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Assertion clocked by clk_i and disabled while rst_ni is low.
`define FSPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Assertion clocked by clk_i that also holds during reset.
`define FSPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define FSPS_ASSERT(lbl, prop, msg)
`define FSPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/fsps_pkg.sv
// ----------------------------------------------------------------------------
// Four-step pitch sequencer package
// Types and constants shared by the sequencer and its serial divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsps_pkg;

  localparam int unsigned DIVIDEND_W = 31;
  localparam int unsigned DIVISOR_W  = 16;
  localparam int unsigned BEAT_W     = 34;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned PITCH_W    = 16;
  localparam int unsigned LFSR_W     = 16;

  localparam logic [PHASE_W-1:0] SAMPLE_STEP = 32'd256;
  localparam logic [PHASE_W-1:0] SPS_RESET   = 32'd6144000;
  localparam logic [15:0]        BPS_RESET   = 16'd256;
  localparam logic [LFSR_W-1:0]  LFSR_SEED   = 16'hACE1;
  localparam logic [LFSR_W-1:0]  LFSR_TAPS   = 16'hB400;

  localparam logic [2:0] MODE_FORWARD  = 3'd0;
  localparam logic [2:0] MODE_BACKWARD = 3'd1;
  localparam logic [2:0] MODE_RANDOM   = 3'd2;
  localparam logic [2:0] MODE_PINGPONG = 3'd3;
  localparam logic [2:0] MODE_LOOP2    = 3'd4;
  localparam logic [2:0] MODE_LOOP3    = 3'd5;
  localparam logic [2:0] MODE_LOOP4    = 3'd6;

  localparam logic [2:0] REG_ORDER_MODE  = 3'd0;
  localparam logic [2:0] REG_SAMPLES     = 3'd1;
  localparam logic [2:0] REG_BEATS       = 3'd2;
  localparam logic [2:0] REG_HOST_SYNC   = 3'd3;
  localparam logic [2:0] REG_ENABLED     = 3'd4;
  localparam logic [2:0] REG_PITCH_TABLE = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } seq_state_e;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: rtl/fsps_div.sv
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring division that retires one quotient bit per clock cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsps_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fsps_pkg::div_req_t req_i,
  output fsps_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(fsps_pkg::DIVIDEND_W);

  logic                            busy_q, busy_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [fsps_pkg::DIVISOR_W-1:0]  rem_q, rem_d;
  logic [fsps_pkg::DIVIDEND_W-1:0] quo_q, quo_d;
  logic [fsps_pkg::DIVISOR_W-1:0]  dsr_q, dsr_d;
  logic [fsps_pkg::DIVISOR_W:0]    trial;
  logic [fsps_pkg::DIVISOR_W:0]    diff;
  logic                            fits;

  always_comb begin
    trial = {rem_q, quo_q[fsps_pkg::DIVIDEND_W-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = trial >= {1'b0, dsr_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(fsps_pkg::DIVIDEND_W - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[fsps_pkg::DIVISOR_W-1:0] : trial[fsps_pkg::DIVISOR_W-1:0];
      quo_d = {quo_q[fsps_pkg::DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: rtl/four_step_pitch_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Four-step pitch sequencer
// Returns the pitch of the current step for each sample item (zero while
// disabled) and advances the step by free-run phase, host song position or manual trigger.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       sink       in_valid_i/in_stall_o action, tempo, transport, position
//  out      source     out_valid_o/out_stall_i pitch_offset, step_index
//  cfg      sink       cfg_we_i              cfg_index_i, cfg_data_i
//
// A trigger item is taken in the idle state. A free-run or disabled sample
// item goes on to the finish state; a host-sync sample item first passes the
// divide state, where the serial divider forms the 31-bit step-beat number one
// quotient bit per cycle. The input is stalled while an item is in progress;
// a stalled result holds the block in the finish state. Reset is asynchronous.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "four_step_pitch_sequencer_unit_defines.svh"

module four_step_pitch_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic        tempo_positive_i,
  input  logic        transport_playing_i,
  input  logic signed [39:0] song_position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] pitch_offset_o,
  output logic [1:0]  step_index_o
);

  fsps_pkg::seq_state_e state_q, state_d;

  logic [2:0]                   order_mode_q;
  logic [fsps_pkg::PHASE_W-1:0] samples_q;
  logic [15:0]                  beats_q;
  logic                         host_sync_q;
  logic                         enabled_q;
  logic [63:0]                  pitch_table_q;

  logic [1:0]                   current_step_q;
  logic                         ping_dir_q;
  logic [fsps_pkg::PHASE_W-1:0] phase_q;
  logic [fsps_pkg::BEAT_W-1:0]  last_beat_q;
  logic [fsps_pkg::LFSR_W-1:0]  lfsr_q;
  logic                         sync_q;
  logic                         neg_q;

  logic                         out_valid_q;
  logic [fsps_pkg::PITCH_W-1:0] pitch_q;
  logic [1:0]                   step_out_q;

  fsps_pkg::div_req_t div_req;
  fsps_pkg::div_rsp_t div_rsp;

  logic        in_fire;
  logic        sync_path;
  logic        out_free;
  logic        finish_fire;
  logic        trig_fire;
  logic [31:0] pos_beats;

  logic [1:0]                   adv_step;
  logic                         adv_dir;
  logic [fsps_pkg::LFSR_W-1:0]  adv_lfsr;
  logic [fsps_pkg::LFSR_W-1:0]  lfsr_shift;

  logic [fsps_pkg::BEAT_W-1:0]  beat_num;
  logic                         sync_adv;
  logic [fsps_pkg::PHASE_W:0]   phase_sum;
  logic [fsps_pkg::PHASE_W-1:0] period;
  logic                         free_adv;
  logic [fsps_pkg::PHASE_W:0]   phase_wrap;
  logic [fsps_pkg::PHASE_W-1:0] phase_next;
  logic                         do_adv;
  logic [1:0]                   sel_step;

  assign in_fire   = in_valid_i && !in_stall_o;
  assign sync_path = enabled_q && host_sync_q && transport_playing_i && tempo_positive_i;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign trig_fire = in_fire && action_i && enabled_q;
  assign pos_beats = song_position_i[39:8];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fsps_pkg::ST_IDLE: begin
        if (in_fire && !action_i) begin
          state_d = sync_path ? fsps_pkg::ST_DIVIDE : fsps_pkg::ST_FINISH;
        end
      end
      fsps_pkg::ST_DIVIDE: begin
        if (!div_rsp.busy) begin
          state_d = fsps_pkg::ST_FINISH;
        end
      end
      fsps_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = fsps_pkg::ST_IDLE;
        end
      end
      default: state_d = fsps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o       = (state_q != fsps_pkg::ST_IDLE);
    finish_fire      = (state_q == fsps_pkg::ST_FINISH) && out_free;
    div_req.start    = in_fire && !action_i && sync_path;
    div_req.dividend = pos_beats[31] ? ~pos_beats[30:0] : pos_beats[30:0];
    div_req.divisor  = (beats_q == '0) ? 16'd1 : beats_q;
  end

  fsps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    lfsr_shift = lfsr_q >> 1;
    adv_lfsr   = lfsr_q[0] ? (lfsr_shift ^ fsps_pkg::LFSR_TAPS) : lfsr_shift;
    adv_step   = current_step_q;
    adv_dir    = ping_dir_q;
    unique case (order_mode_q)
      fsps_pkg::MODE_FORWARD, fsps_pkg::MODE_LOOP4: adv_step = current_step_q + 2'd1;
      fsps_pkg::MODE_BACKWARD: adv_step = current_step_q - 2'd1;
      fsps_pkg::MODE_RANDOM:   adv_step = adv_lfsr[1:0];
      fsps_pkg::MODE_PINGPONG: begin
        if (ping_dir_q) begin
          if (current_step_q >= 2'd2) begin
            adv_step = 2'd3;
            adv_dir  = 1'b0;
          end else begin
            adv_step = current_step_q + 2'd1;
          end
        end else begin
          if (current_step_q <= 2'd1) begin
            adv_step = 2'd0;
            adv_dir  = 1'b1;
          end else begin
            adv_step = current_step_q - 2'd1;
          end
        end
      end
      fsps_pkg::MODE_LOOP2: adv_step = {1'b0, ~current_step_q[0]};
      fsps_pkg::MODE_LOOP3: begin
        unique case (current_step_q)
          2'd0:    adv_step = 2'd1;
          2'd1:    adv_step = 2'd2;
          2'd2:    adv_step = 2'd0;
          default: adv_step = 2'd1;
        endcase
      end
      default: adv_step = current_step_q;
    endcase
  end

  always_comb begin
    beat_num   = neg_q ? ~{3'b000, div_rsp.quotient} : {3'b000, div_rsp.quotient};
    sync_adv   = (beat_num != last_beat_q) && !last_beat_q[fsps_pkg::BEAT_W-1];
    period     = (samples_q < fsps_pkg::SAMPLE_STEP) ? fsps_pkg::SAMPLE_STEP : samples_q;
    phase_sum  = {1'b0, phase_q} + {1'b0, fsps_pkg::SAMPLE_STEP};
    free_adv   = phase_sum >= {1'b0, period};
    phase_wrap = phase_sum - {1'b0, period};
    phase_next = free_adv ? phase_wrap[fsps_pkg::PHASE_W-1:0]
                          : phase_sum[fsps_pkg::PHASE_W-1:0];
    do_adv     = trig_fire ||
                 (finish_fire && enabled_q && (sync_q ? sync_adv : free_adv));
    sel_step   = do_adv ? adv_step : current_step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_mode_q   <= fsps_pkg::MODE_FORWARD;
      samples_q      <= fsps_pkg::SPS_RESET;
      beats_q        <= fsps_pkg::BPS_RESET;
      host_sync_q    <= 1'b0;
      enabled_q      <= 1'b0;
      pitch_table_q  <= '0;
      current_step_q <= '0;
      ping_dir_q     <= 1'b1;
      phase_q        <= '0;
      last_beat_q    <= '1;
      lfsr_q         <= fsps_pkg::LFSR_SEED;
      sync_q         <= 1'b0;
      neg_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          fsps_pkg::REG_ORDER_MODE:  order_mode_q  <= cfg_data_i[2:0];
          fsps_pkg::REG_SAMPLES:     samples_q     <= cfg_data_i[31:0];
          fsps_pkg::REG_BEATS:       beats_q       <= cfg_data_i[15:0];
          fsps_pkg::REG_HOST_SYNC:   host_sync_q   <= cfg_data_i[0];
          fsps_pkg::REG_ENABLED: begin
            enabled_q <= cfg_data_i[0];
            if (!cfg_data_i[0]) begin
              current_step_q <= '0;
              ping_dir_q     <= 1'b1;
              phase_q        <= '0;
              last_beat_q    <= '1;
            end
          end
          fsps_pkg::REG_PITCH_TABLE: pitch_table_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire && !action_i) begin
        sync_q <= sync_path;
        neg_q  <= pos_beats[31];
      end
      if (do_adv) begin
        current_step_q <= adv_step;
        ping_dir_q     <= adv_dir;
        if (order_mode_q == fsps_pkg::MODE_RANDOM) begin
          lfsr_q <= adv_lfsr;
        end
      end
      if (finish_fire && enabled_q) begin
        if (sync_q) begin
          last_beat_q <= beat_num;
        end else begin
          phase_q <= phase_next;
        end
      end
      if (finish_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish_fire) begin
      pitch_q    <= enabled_q ? pitch_table_q[16*sel_step +: 16] : '0;
      step_out_q <= sel_step;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pitch_offset_o = pitch_q;
  assign step_index_o   = step_out_q;

  `FSPS_ASSERT(a_div_busy_in_divide, div_rsp.busy |-> (state_q == fsps_pkg::ST_DIVIDE), "divider busy outside divide state")
  `FSPS_ASSERT(a_disabled_cleared, !enabled_q |-> (phase_q == '0 && current_step_q == '0 && ping_dir_q), "run state not cleared while disabled")
  `FSPS_ASSERT(a_lfsr_nonzero, lfsr_q != '0, "random generator reached the all-zero state")
  `FSPS_ASSERT(a_result_from_finish, $rose(out_valid_q) |-> ($past(state_q) == fsps_pkg::ST_FINISH), "result raised outside the finish state")

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Four-step pitch sequencer testbench
// Sends sample and trigger items to the sequencer and checks every pitch
// result against a predictor that tracks the step, the free-run phase, the
// host beat number and the random generator. Each phase sets the registers
// while the block is idle, then runs directed or random items with bursty
// input, a random output stall and one long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int          RANDOM_ITEMS   = 1150;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          PRESSURE_PHASE = 3;
  localparam int          PRESSURE_HOLD  = 400;
  localparam logic [2:0]  MODE_UNUSED    = 3'd7;
  localparam logic        ACT_SAMPLE     = 1'b0;
  localparam logic        ACT_TRIGGER    = 1'b1;

  typedef struct packed {
    logic               action;
    logic               tempo_positive;
    logic               transport_playing;
    logic signed [39:0] song_position;
  } seq_item_t;

  typedef struct packed {
    logic signed [15:0] pitch_offset;
    logic [1:0]         step_index;
  } pitch_result_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HALF,
    RX_HEAVY
  } rx_pattern_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_index_i = '0;
  logic [63:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               action_i = 1'b0;
  logic               tempo_positive_i = 1'b0;
  logic               transport_playing_i = 1'b0;
  logic signed [39:0] song_position_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [15:0] pitch_offset_o;
  logic [1:0]         step_index_o;

  four_step_pitch_sequencer_unit uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .action_i            (action_i),
    .tempo_positive_i    (tempo_positive_i),
    .transport_playing_i (transport_playing_i),
    .song_position_i     (song_position_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .pitch_offset_o      (pitch_offset_o),
    .step_index_o        (step_index_o)
  );

  always #1 clk_i = ~clk_i;

  // Register copies and sequencer state as the predictor sees them.
  logic [2:0]  cfg_mode      = fsps_pkg::MODE_FORWARD;
  logic [31:0] cfg_samples   = fsps_pkg::SPS_RESET;
  logic [15:0] cfg_beats     = fsps_pkg::BPS_RESET;
  logic        cfg_sync      = 1'b0;
  logic        cfg_enabled   = 1'b0;
  logic [63:0] cfg_pitches   = '0;
  logic [1:0]  cur_step      = 2'd0;
  logic        dir_up        = 1'b1;
  logic [31:0] phase_acc     = '0;
  longint      last_beat_num = -1;
  logic [15:0] lfsr_state    = fsps_pkg::LFSR_SEED;

  seq_item_t     seq_item_q[$];
  pitch_result_t pitch_due_q[$];
  int            offered_cnt = 0;
  int            taken_cnt = 0;
  int            fail_count = 0;
  int            stimulus_count = 0;
  int            gap_left = 0;
  int            burst_left = 0;
  int            idle_cycles = 0;
  logic          pressure_go = 1'b0;
  logic          pressure_done = 1'b0;
  int            hold_count = 0;
  int            stall_run_left = 0;
  rx_pattern_e   stall_style = RX_FREE;

  function automatic void clear_run_state();
    cur_step      = 2'd0;
    dir_up        = 1'b1;
    phase_acc     = '0;
    last_beat_num = -1;
  endfunction

  function automatic void advance_pitch_step();
    logic [1:0] s;
    logic       lsb;
    s = cur_step;
    case (cfg_mode)
      fsps_pkg::MODE_FORWARD, fsps_pkg::MODE_LOOP4: s = s + 2'd1;
      fsps_pkg::MODE_BACKWARD: s = s - 2'd1;
      fsps_pkg::MODE_RANDOM: begin
        lsb = lfsr_state[0];
        lfsr_state = lfsr_state >> 1;
        if (lsb) begin
          lfsr_state = lfsr_state ^ fsps_pkg::LFSR_TAPS;
        end
        s = lfsr_state[1:0];
      end
      fsps_pkg::MODE_PINGPONG: begin
        if (dir_up) begin
          if (s >= 2'd2) begin
            s = 2'd3;
            dir_up = 1'b0;
          end else begin
            s = s + 2'd1;
          end
        end else begin
          if (s <= 2'd1) begin
            s = 2'd0;
            dir_up = 1'b1;
          end else begin
            s = s - 2'd1;
          end
        end
      end
      fsps_pkg::MODE_LOOP2: s = 2'((int'(s) + 1) % 2);
      fsps_pkg::MODE_LOOP3: s = 2'((int'(s) + 1) % 3);
      default: ;
    endcase
    cur_step = s;
  endfunction

  function automatic pitch_result_t sample_pitch(input logic tempo, input logic playing,
                                                 input logic signed [39:0] pos);
    pitch_result_t r;
    longint        divisor;
    longint        pos_l;
    longint        beat;
    logic [63:0]   ph;
    logic [63:0]   period;
    if (!cfg_enabled) begin
      r.pitch_offset = '0;
      r.step_index   = cur_step;
      return r;
    end
    if (cfg_sync && playing && tempo) begin
      divisor = longint'((cfg_beats == 16'd0) ? 16'd1 : cfg_beats) * 256;
      pos_l = longint'(pos);
      beat = pos_l / divisor;
      if (pos_l % divisor != 0 && pos_l < 0) begin
        beat = beat - 1;
      end
      if (beat != last_beat_num && last_beat_num >= 0) begin
        advance_pitch_step();
      end
      last_beat_num = beat;
    end else begin
      period = (cfg_samples < fsps_pkg::SAMPLE_STEP) ? {32'd0, fsps_pkg::SAMPLE_STEP}
                                                     : {32'd0, cfg_samples};
      ph = {32'd0, phase_acc} + {32'd0, fsps_pkg::SAMPLE_STEP};
      if (ph >= period) begin
        ph = ph - period;
        advance_pitch_step();
      end
      phase_acc = ph[31:0];
    end
    r.pitch_offset = cfg_pitches[16*cur_step +: 16];
    r.step_index   = cur_step;
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] reg_index, input logic [63:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= reg_index;
    cfg_data_i  <= value;
    case (reg_index)
      fsps_pkg::REG_ORDER_MODE:  cfg_mode = value[2:0];
      fsps_pkg::REG_SAMPLES:     cfg_samples = value[31:0];
      fsps_pkg::REG_BEATS:       cfg_beats = value[15:0];
      fsps_pkg::REG_HOST_SYNC:   cfg_sync = value[0];
      fsps_pkg::REG_ENABLED: begin
        cfg_enabled = value[0];
        if (!cfg_enabled) begin
          clear_run_state();
        end
      end
      fsps_pkg::REG_PITCH_TABLE: cfg_pitches = value;
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_item(input logic act, input logic tempo, input logic playing,
                           input logic signed [39:0] pos);
    seq_item_t it;
    it.action            = act;
    it.tempo_positive    = tempo;
    it.transport_playing = playing;
    it.song_position     = pos;
    seq_item_q.push_back(it);
  endtask

  task automatic settle_block();
    while (seq_item_q.size() != 0 || taken_cnt != offered_cnt || pitch_due_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [39:0] random_position();
    logic [63:0] wide;
    wide = {$urandom(), $urandom()};
    return wide[39:0];
  endfunction

  task automatic randomize_settings();
    logic [63:0] value;
    if ($urandom_range(0, 1) == 0) begin
      write_reg(fsps_pkg::REG_ORDER_MODE,
                64'($urandom_range(fsps_pkg::MODE_FORWARD, MODE_UNUSED)));
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 7))
        0: value = 64'd0;
        1: value = 64'd255;
        2: value = 64'd256;
        3: value = 64'hFFFF_FFFF;
        4: value = 64'($urandom());
        default: value = 64'($urandom_range(256, 4096));
      endcase
      write_reg(fsps_pkg::REG_SAMPLES, value);
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 6))
        0: value = 64'd0;
        1: value = 64'd1;
        2: value = 64'd65535;
        3: value = 64'($urandom_range(0, 65535));
        default: value = 64'($urandom_range(1, 16));
      endcase
      write_reg(fsps_pkg::REG_BEATS, value);
    end
    if ($urandom_range(0, 1) == 0) begin
      write_reg(fsps_pkg::REG_HOST_SYNC, 64'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 1) == 0) begin
      write_reg(fsps_pkg::REG_PITCH_TABLE, {$urandom(), $urandom()});
    end
    if ($urandom_range(0, 4) == 0) begin
      write_reg(fsps_pkg::REG_ENABLED, 64'd0);
    end
    write_reg(fsps_pkg::REG_ENABLED, ($urandom_range(0, 99) < 85) ? 64'd1 : 64'd0);
    finish_writes();
  endtask

  // Mostly runs of advancing song positions with the host playing, mixed
  // with triggers, stopped transport and jumps to arbitrary positions.
  task automatic queue_random_items(input int count);
    int unsigned        beat_span;
    int                 r;
    logic signed [39:0] pos;
    beat_span = ((cfg_beats == 16'd0) ? 1 : int'(cfg_beats)) * 256;
    case ($urandom_range(0, 3))
      0: pos = 40'sd0 - 40'($urandom_range(0, 2 * beat_span));
      1: pos = random_position();
      2: pos = '0;
      default: pos = 40'($urandom());
    endcase
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        push_item(ACT_TRIGGER, 1'($urandom()), 1'($urandom()), random_position());
        if (cfg_enabled) begin
          stimulus_count++;
        end
      end else begin
        stimulus_count++;
        if (r < 20) begin
          push_item(ACT_SAMPLE, 1'($urandom()), 1'($urandom()), random_position());
        end else if (r < 24) begin
          pos = random_position();
          push_item(ACT_SAMPLE, 1'b1, 1'b1, pos);
        end else begin
          pos = pos + 40'($urandom_range(0, beat_span + beat_span / 2));
          push_item(ACT_SAMPLE, 1'b1, 1'b1, pos);
        end
      end
    end
  endtask

  always @(negedge clk_i) begin : item_driver
    seq_item_t next_item;
    if (!in_valid_i || taken_cnt == offered_cnt) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (seq_item_q.size() != 0) begin
        next_item = seq_item_q.pop_front();
        in_valid_i          <= 1'b1;
        action_i            <= next_item.action;
        tempo_positive_i    <= next_item.tempo_positive;
        transport_playing_i <= next_item.transport_playing;
        song_position_i     <= next_item.song_position;
        offered_cnt++;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 31);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : item_intake
    if (rst_ni && in_valid_i && !in_stall_o) begin
      taken_cnt++;
      if (action_i) begin
        if (cfg_enabled) begin
          advance_pitch_step();
        end
      end else begin
        pitch_due_q.push_back(sample_pitch(tempo_positive_i, transport_playing_i,
                                           song_position_i));
      end
    end
  end

  always @(negedge clk_i) begin : result_stall
    if (pressure_go && !pressure_done) begin
      out_stall_i <= 1'b1;
      hold_count++;
      if (hold_count == PRESSURE_HOLD) begin
        pressure_done = 1'b1;
      end
    end else begin
      if (stall_run_left == 0) begin
        stall_style = rx_pattern_e'($urandom_range(0, 3));
        stall_run_left = $urandom_range(20, 200);
      end
      stall_run_left--;
      case (stall_style)
        RX_FREE:  out_stall_i <= 1'b0;
        RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_HALF:  out_stall_i <= ($urandom_range(0, 1) == 0);
        default:  out_stall_i <= ($urandom_range(0, 15) < 13);
      endcase
    end
  end

  always @(posedge clk_i) begin : result_check
    pitch_result_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pitch_due_q.size() == 0) begin
        $error("unexpected result: pitch_offset %0d step_index %0d",
               pitch_offset_o, step_index_o);
        fail_count++;
      end else begin
        due = pitch_due_q.pop_front();
        if (pitch_offset_o !== due.pitch_offset) begin
          $error("pitch_offset mismatch: expected %0d, actual %0d",
                 due.pitch_offset, pitch_offset_o);
          fail_count++;
        end
        if (step_index_o !== due.step_index) begin
          $error("step_index mismatch: expected %0d, actual %0d",
                 due.step_index, step_index_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == WATCHDOG_LIMIT) begin
          $display("four_step_pitch_sequencer_unit test failed");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int phase_no;
    phase_no = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Disabled after reset: a sample gives zero, a trigger is ignored.
    push_item(ACT_SAMPLE, 1'b0, 1'b0, 40'sd0);
    push_item(ACT_TRIGGER, 1'b1, 1'b1, -40'sd1);
    push_item(ACT_SAMPLE, 1'b1, 1'b1, 40'sh7F_FFFF_FFFF);
    settle_block();

    // A period below one sample advances on every sample.
    write_reg(fsps_pkg::REG_PITCH_TABLE, 64'h8000_7FFF_0100_FF80);
    write_reg(fsps_pkg::REG_ORDER_MODE, 64'(fsps_pkg::MODE_FORWARD));
    write_reg(fsps_pkg::REG_SAMPLES, 64'd0);
    write_reg(fsps_pkg::REG_BEATS, 64'd0);
    write_reg(fsps_pkg::REG_HOST_SYNC, 64'd0);
    write_reg(fsps_pkg::REG_ENABLED, 64'd1);
    finish_writes();
    push_item(ACT_SAMPLE, 1'b0, 1'b0, 40'sd0);
    push_item(ACT_SAMPLE, 1'b0, 1'b0, 40'sd0);
    push_item(ACT_TRIGGER, 1'b0, 1'b0, 40'sd0);
    push_item(ACT_SAMPLE, 1'b0, 1'b0, 40'sd0);
    settle_block();

    write_reg(fsps_pkg::REG_ORDER_MODE, 64'(fsps_pkg::MODE_PINGPONG));
    write_reg(fsps_pkg::REG_SAMPLES, 64'hFFFF_FFFF);
    finish_writes();
    repeat (3) push_item(ACT_TRIGGER, 1'b0, 1'b0, 40'sd0);
    push_item(ACT_SAMPLE, 1'b0, 1'b0, 40'sd0);
    push_item(ACT_TRIGGER, 1'b0, 1'b0, 40'sd0);
    push_item(ACT_SAMPLE, 1'b0, 1'b0, 40'sd0);
    settle_block();

    // The two-step loop entered from outside the loop.
    write_reg(fsps_pkg::REG_ORDER_MODE, 64'(fsps_pkg::MODE_LOOP2));
    finish_writes();
    push_item(ACT_TRIGGER, 1'b0, 1'b0, 40'sd0);
    push_item(ACT_SAMPLE, 1'b0, 1'b0, 40'sd0);
    settle_block();

    write_reg(fsps_pkg::REG_ORDER_MODE, 64'(MODE_UNUSED));
    finish_writes();
    push_item(ACT_TRIGGER, 1'b0, 1'b0, 40'sd0);
    push_item(ACT_SAMPLE, 1'b0, 1'b0, 40'sd0);
    settle_block();

    write_reg(fsps_pkg::REG_ORDER_MODE, 64'(fsps_pkg::MODE_BACKWARD));
    finish_writes();
    push_item(ACT_TRIGGER, 1'b0, 1'b0, 40'sd0);
    push_item(ACT_SAMPLE, 1'b0, 1'b0, 40'sd0);
    settle_block();

    // Host sync with a zero beat length, negative beats and position extremes.
    write_reg(fsps_pkg::REG_ORDER_MODE, 64'(fsps_pkg::MODE_FORWARD));
    write_reg(fsps_pkg::REG_SAMPLES, 64'd256);
    write_reg(fsps_pkg::REG_HOST_SYNC, 64'd1);
    finish_writes();
    push_item(ACT_SAMPLE, 1'b1, 1'b1, -40'sd1);
    push_item(ACT_SAMPLE, 1'b1, 1'b1, 40'sh80_0000_0000);
    push_item(ACT_SAMPLE, 1'b1, 1'b1, 40'sd0);
    push_item(ACT_SAMPLE, 1'b1, 1'b1, 40'sd256);
    push_item(ACT_SAMPLE, 1'b1, 1'b1, 40'sd511);
    push_item(ACT_SAMPLE, 1'b1, 1'b1, 40'sh7F_FFFF_FFFF);
    push_item(ACT_SAMPLE, 1'b1, 1'b0, 40'sd512);
    push_item(ACT_SAMPLE, 1'b0, 1'b1, 40'sd768);
    settle_block();

    while (stimulus_count < RANDOM_ITEMS) begin
      randomize_settings();
      if (phase_no == PRESSURE_PHASE) begin
        pressure_go = 1'b1;
      end
      queue_random_items($urandom_range(20, 60));
      settle_block();
      phase_no++;
    end

    if (fail_count == 0) begin
      $display("four_step_pitch_sequencer_unit test passed");
    end else begin
      $display("four_step_pitch_sequencer_unit test failed");
    end
    $finish;
  end

endmodule
